### hdl/mu8sl_pkg.sv
`timescale 1ns / 1ps

package mu8sl_pkg;

    localparam int BODY_MAX = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // what closes the literal after this byte's characters
    typedef enum logic [1:0] {
        CL_NONE,
        CL_QUOTE,
        CL_ERROR
    } t_close;

    // one classified input byte: optional opening quote, up to six body
    // characters, optional closing quote or error beat
    typedef struct packed {
        logic                            open;
        logic [2:0]                      len;
        logic [BODY_MAX-1:0][7:0]        body;
        t_close                          close;
    } t_cmd;

    function automatic logic [7:0] hex_ascii(input logic [3:0] d);
        hex_ascii = (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
    endfunction

endpackage

### hdl/mu8sl_front.sv
`timescale 1ns / 1ps

module mu8sl_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output mu8sl_pkg::t_cmd  o_cmd
);
    import mu8sl_pkg::*;

    typedef enum logic [1:0] {
        K_NONE,
        K_TWO,
        K_THREE,
        K_PAIR
    } t_kind;

    logic        r_started, n_started;
    logic [2:0]  r_pending, n_pending;
    t_kind       r_kind,    n_kind;
    logic [19:0] r_bits,    n_bits;

    logic        accept;
    logic        fin;
    logic        do_uesc;
    logic [4:0]  ucode;
    logic [7:0]  esc;
    logic [15:0] code;
    logic [20:0] cp;
    logic [3:0]  count;
    t_cmd        cmd;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    always_comb begin
        n_started = 1'b1;
        n_pending = r_pending;
        n_kind    = r_kind;
        n_bits    = r_bits;
        cmd.open  = !r_started;
        cmd.len   = 3'd0;
        cmd.body  = '0;
        cmd.close = CL_NONE;
        fin       = 1'b0;
        do_uesc   = 1'b0;
        ucode     = 5'd0;
        esc       = 8'h00;
        code      = 16'h0000;
        cp        = 21'h0;

        if (i_byte == 8'h00) begin
            fin = 1'b1;
        end else if (r_pending != 3'd0) begin
            if (r_kind == K_PAIR) begin
                case (r_pending)
                    3'd5: n_bits = r_bits | {i_byte[3:0], 16'h0000};
                    3'd4: n_bits = r_bits | {4'h0, i_byte[5:0], 10'h000};
                    3'd3: n_bits = r_bits;  // second 0xED lead, skipped
                    3'd2: n_bits = r_bits | {10'h000, i_byte[3:0], 6'h00};
                    default: begin
                        cp = {1'b0, r_bits | {14'h0000, i_byte[5:0]}} + 21'h10000;
                        cmd.len     = 3'd4;
                        cmd.body[0] = {5'b11110, cp[20:18]};
                        cmd.body[1] = {2'b10, cp[17:12]};
                        cmd.body[2] = {2'b10, cp[11:6]};
                        cmd.body[3] = {2'b10, cp[5:0]};
                    end
                endcase
                n_pending = r_pending - 3'd1;
            end else if (r_pending > 3'd1) begin
                n_bits    = {r_bits[11:0], i_byte};
                n_pending = r_pending - 3'd1;
            end else begin
                if (r_kind == K_TWO) begin
                    code = {5'h00, r_bits[4:0], i_byte[5:0]};
                end else begin
                    code = {r_bits[11:8], r_bits[5:0], i_byte[5:0]};
                end
                if (code < 16'h0020) begin
                    do_uesc = 1'b1;
                    ucode   = code[4:0];
                end else if (r_kind == K_THREE) begin
                    cmd.len     = 3'd3;
                    cmd.body[0] = r_bits[15:8];
                    cmd.body[1] = r_bits[7:0];
                    cmd.body[2] = i_byte;
                end else begin
                    cmd.len     = 3'd2;
                    cmd.body[0] = r_bits[7:0];
                    cmd.body[1] = i_byte;
                end
                n_pending = 3'd0;
            end
            if (n_pending == 3'd0) begin
                n_kind = K_NONE;
                n_bits = 20'h00000;
            end
        end else begin
            unique case (i_byte)
                8'h22:   esc = 8'h22;
                8'h5C:   esc = 8'h5C;
                8'h08:   esc = 8'h62;
                8'h09:   esc = 8'h74;
                8'h0A:   esc = 8'h6E;
                8'h0C:   esc = 8'h66;
                8'h0D:   esc = 8'h72;
                default: esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                cmd.len     = 3'd2;
                cmd.body[0] = CH_BSLASH;
                cmd.body[1] = esc;
            end else if (i_byte[7:5] == 3'b110) begin
                n_kind    = K_TWO;
                n_pending = 3'd1;
                n_bits    = {12'h000, i_byte};
            end else if (i_byte == 8'hED) begin
                n_kind    = K_PAIR;
                n_pending = 3'd5;
                n_bits    = 20'h00000;
            end else if (i_byte[7:4] == 4'hE) begin
                n_kind    = K_THREE;
                n_pending = 3'd2;
                n_bits    = {12'h000, i_byte};
            end else if (i_byte < 8'h20) begin
                do_uesc = 1'b1;
                ucode   = i_byte[4:0];
            end else begin
                cmd.len     = 3'd1;
                cmd.body[0] = i_byte;
            end
        end

        if (do_uesc) begin
            cmd.len     = 3'd6;
            cmd.body[0] = CH_BSLASH;
            cmd.body[1] = CH_U;
            cmd.body[2] = CH_ZERO;
            cmd.body[3] = CH_ZERO;
            cmd.body[4] = hex_ascii({3'b000, ucode[4]});
            cmd.body[5] = hex_ascii(ucode[3:0]);
        end

        if (i_last) begin
            fin = 1'b1;
        end
        if (fin) begin
            cmd.close = (n_pending != 3'd0) ? CL_ERROR : CL_QUOTE;
            n_started = 1'b0;
            n_pending = 3'd0;
            n_kind    = K_NONE;
            n_bits    = 20'h00000;
        end
    end

    assign count  = {3'b000, cmd.open} + {1'b0, cmd.len} + {3'b000, cmd.close != CL_NONE};
    assign o_push = accept && (count != 4'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pending <= 3'd0;
            r_kind    <= K_NONE;
            r_bits    <= 20'h00000;
        end else if (accept) begin
            r_started <= n_started;
            r_pending <= n_pending;
            r_kind    <= n_kind;
            r_bits    <= n_bits;
        end
    end

    a_kind_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 3'd0) == (r_kind == K_NONE))
        else $error("sequence kind and pending count disagree");

endmodule

### hdl/mu8sl_queue.sv
`timescale 1ns / 1ps

module mu8sl_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mu8sl_pkg::t_cmd  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output mu8sl_pkg::t_cmd  o_data,
    output logic             o_empty
);
    import mu8sl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### hdl/mu8sl_back.sv
`timescale 1ns / 1ps

module mu8sl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mu8sl_pkg::t_cmd  i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_char,
    output logic             o_last,
    output logic             o_error
);
    import mu8sl_pkg::*;

    logic       r_valid;
    logic [2:0] r_idx;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_error;

    logic [3:0] total;
    logic [2:0] j;
    logic       load;
    logic       final_item;
    logic [7:0] n_char;
    logic       n_last;
    logic       n_error;

    assign total = {3'b000, i_head.open} + {1'b0, i_head.len}
                 + {3'b000, i_head.close != CL_NONE};
    assign j          = r_idx - {2'b00, i_head.open};
    assign load       = !i_empty && (!r_valid || !i_stall);
    assign final_item = ({1'b0, r_idx} == (total - 4'd1));
    assign o_pop      = load && final_item;

    always_comb begin
        n_char  = 8'h00;
        n_last  = 1'b0;
        n_error = 1'b0;
        if (i_head.open && (r_idx == 3'd0)) begin
            n_char = CH_QUOTE;
        end else if (j < i_head.len) begin
            n_char = i_head.body[j];
        end else begin
            case (i_head.close)
                CL_QUOTE: begin
                    n_char = CH_QUOTE;
                    n_last = 1'b1;
                end
                CL_ERROR: begin
                    n_last  = 1'b1;
                    n_error = 1'b1;
                end
                default: n_char = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= final_item ? 3'd0 : r_idx + 3'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= n_char;
            r_last  <= n_last;
            r_error <= n_error;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_error = r_error;

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_error) |-> (r_last && (r_char == 8'h00)))
        else $error("error beat not marked last");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> !i_empty)
        else $error("command left the queue before all its beats were sent");

endmodule

### hdl/modified_utf8_to_string_literal.sv
`timescale 1ns / 1ps

// Converts a stream of Java modified UTF-8 bytes into a double-quoted string
// literal, one output byte per beat. The first byte of a string yields an
// opening quote; quote, backslash, BS, TAB, LF, FF and CR become backslash
// escapes; other bytes and two-/three-byte codes below 0x20 become \uXXXX,
// uppercase hex; the rest pass raw. A 0xED surrogate pair (six bytes) is
// re-encoded as four-byte UTF-8 of 0x10000 plus its 20 payload bits. A zero
// byte or i_last ends the string with a closing quote, or, if a multi-byte
// sequence was cut off, with a beat of o_char 0, o_last 1, o_error 1.
// Rate: the front end classifies one byte per cycle unless the command
// queue is full, and queues a command; the back end sends one output beat
// per cycle unless the queue is empty or i_stall is high. A byte yields 0
// to 8 output beats; the command queue (QUEUE_DEPTH entries) absorbs
// bursts so input and output stall independently.

module modified_utf8_to_string_literal #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    output logic       o_out_error
);
    import mu8sl_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd_in;
    t_cmd cmd_head;

    // front: byte classification and sequence state
    mu8sl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    // queue of per-byte commands between the two halves
    mu8sl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (cmd_head),
        .o_empty (empty)
    );

    // back: expands each command into output beats, registered output
    mu8sl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (cmd_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_char  (o_out_char),
        .o_last  (o_out_last),
        .o_error (o_out_error)
    );

endmodule
